// ===== hw/rtl/lcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and sizes for the byte-capped LRU cache.
// No dependencies; imported by every module of the block.
package lcc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int DATA_W  = 32;
  localparam int USED_W  = DATA_W + 1;   // store sum may carry one bit

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] cost;
    logic [DATA_W-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_EVICT   = 3'd1,
    KIND_STORED  = 3'd2,
    KIND_REFUSED = 3'd3,
    KIND_CLEARED = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ORD_NONE,
    ORD_TOUCH,
    ORD_DROP,
    ORD_INSERT,
    ORD_CLEAR
  } ord_op_t;

  typedef struct packed {
    ord_op_t          op;
    logic [IDX_W-1:0] pos;
  } ord_cmd_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_FULL_RD,
    ST_FULL_EV,
    ST_INSERT,
    ST_ADD,
    ST_CHECK,
    ST_EV_RD,
    ST_EV,
    ST_DONE,
    ST_REFUSE,
    ST_CLEAR
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lcc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Entry store: key, cost and payload per slot, one write and one registered read port.
// Depends on lcc_pkg.
module lcc_ram (
  input  wire                      clk,
  input  wire                      we,
  input  wire [lcc_pkg::IDX_W-1:0] waddr,
  input  lcc_pkg::entry_t          wdata,
  input  wire [lcc_pkg::IDX_W-1:0] raddr,
  output lcc_pkg::entry_t          rdata
);
  import lcc_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcc_order.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Recency list: a permutation of slot numbers, oldest first; positions at or
// above count are free slots. Depends on lcc_pkg.
module lcc_order (
  input  wire                      clk,
  input  wire                      rst,
  input  lcc_pkg::ord_cmd_t        cmd,
  input  wire [lcc_pkg::IDX_W-1:0] rd_pos,
  output logic [lcc_pkg::IDX_W-1:0] rd_slot,
  output logic [lcc_pkg::IDX_W-1:0] free_slot,
  output logic [lcc_pkg::CNT_W-1:0] count
);
  import lcc_pkg::*;

  logic [IDX_W-1:0] order      [ENTRIES];
  logic [IDX_W-1:0] order_next [ENTRIES];
  logic [CNT_W-1:0] count_next;

  assign rd_slot   = order[rd_pos];
  assign free_slot = order[count[IDX_W-1:0]];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      order_next[i] = order[i];
    end
    count_next = count;
    case (cmd.op)
      ORD_TOUCH: begin
        // pull entry out at pos, close the gap, put it at the newest place
        for (int i = 0; i < ENTRIES; i++) begin
          if (CNT_W'(i) + CNT_W'(1) == count) begin
            order_next[i] = order[cmd.pos];
          end else if (i < ENTRIES - 1 && IDX_W'(i) >= cmd.pos &&
                       CNT_W'(i) + CNT_W'(1) < count) begin
            order_next[i] = order[IDX_W'((i + 1) % ENTRIES)];
          end
        end
      end
      ORD_DROP: begin
        // rotate: the oldest slot moves into the free region
        for (int i = 0; i < ENTRIES; i++) begin
          order_next[i] = order[IDX_W'((i + 1) % ENTRIES)];
        end
        count_next = count - CNT_W'(1);
      end
      ORD_INSERT: count_next = count + CNT_W'(1);
      ORD_CLEAR:  count_next = '0;
      default:    count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        order[i] <= IDX_W'(i);
      end
      count <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        order[i] <= order_next[i];
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lcc_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte-usage accumulator: the one add / clamped subtract / cap compare unit.
// Depends on lcc_pkg.
module lcc_acc (
  input  wire                       clk,
  input  lcc_pkg::acc_op_t          op,
  input  wire [lcc_pkg::DATA_W-1:0] load_val,
  input  wire [lcc_pkg::DATA_W-1:0] operand,
  input  wire [lcc_pkg::DATA_W-1:0] cap,
  output logic [lcc_pkg::USED_W-1:0] used,
  output logic [lcc_pkg::DATA_W-1:0] diff,
  output logic                       over
);
  import lcc_pkg::*;

  logic [USED_W-1:0] opx;
  logic [USED_W-1:0] diff_full;
  logic [USED_W-1:0] used_next;

  assign opx       = {1'b0, operand};
  assign diff_full = (used >= opx) ? used - opx : '0;
  assign diff      = diff_full[DATA_W-1:0];
  assign over      = used > {1'b0, cap};

  always_comb begin
    case (op)
      ACC_LOAD: used_next = {1'b0, load_val};
      ACC_SUB:  used_next = diff_full;
      ACC_ADD:  used_next = used + opx;
      default:  used_next = used;
    endcase
  end

  always_ff @(posedge clk) begin
    used <= used_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/byte_capped_lru_cache_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the byte-capped LRU cache: sequencer, output register, cap register.
// Depends on lcc_pkg, lcc_ram, lcc_order, lcc_acc.
//
// channel   dir  fields (low bit first)
// s_*       in   tuser: mode[1:0]; tdata: key_tag, cost, payload (96 b)
// m_*       out  tuser: kind[2:0], hit[3]; tdata: out_key, out_cost,
//                out_payload, used_bytes (128 b); tlast: last result of item
// cfg_*     in   cfg_wr_data = mem_cap, written when cfg_wr_en is high
//
// One item at a time; s_tready is high only in idle. A key search reads one
// slot per cycle from the entry RAM, over at most the n live entries (n at
// most 16); a hit ends the search early. A store then rewrites or inserts the
// entry and adds its cost; a full table first drops its oldest entry, and each
// budget eviction drops the oldest remaining one. Each result waits in the
// output register; the sequencer stalls while that register is full.
// Reset (rst, synchronous) empties the table and zeroes the byte total and cap.
module byte_capped_lru_cache_unit (
  input  wire         clk,
  input  wire         rst,
  // input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [95:0]  s_tdata,   // key_tag[31:0], cost[63:32], payload[95:64]
  input  wire [1:0]   s_tuser,   // mode[1:0]
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [127:0] m_tdata,  // out_key, out_cost, out_payload, used_bytes
  output logic [3:0]  m_tuser,   // kind[2:0], hit[3]
  output logic        m_tlast,
  // configuration
  input  wire         cfg_wr_en,
  input  wire [31:0]  cfg_wr_data
);
  import lcc_pkg::*;

  state_t state, state_next;

  // captured item
  logic [1:0]        mode_r;
  logic [DATA_W-1:0] key_r, cost_r, pay_r;
  logic [DATA_W-1:0] mem_cap;
  logic [DATA_W-1:0] used_total;

  // key search
  logic [CNT_W-1:0]  issue_pos;
  logic [IDX_W-1:0]  cmp_pos;
  logic              cmp_vld;
  logic              hit_flag;
  logic [IDX_W-1:0]  hit_pos;
  entry_t            hit_ent;
  logic              match;

  // shared units
  ord_cmd_t          ord_cmd;
  logic [IDX_W-1:0]  rd_pos, rd_slot, free_slot;
  logic [CNT_W-1:0]  count;
  acc_op_t           acc_op;
  logic [DATA_W-1:0] acc_operand;
  logic [USED_W-1:0] used;
  logic [DATA_W-1:0] diff;
  logic              over;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata, rdata;

  // result
  logic              out_free;
  logic              emit;
  kind_t             e_kind;
  logic              e_hit, e_last;
  logic [DATA_W-1:0] e_key, e_cost, e_pay, e_used;

  logic              accept;
  logic              refuse_in;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign match     = cmp_vld && (rdata.key == key_r);
  assign refuse_in = (mem_cap == '0) || (s_tdata[63:32] > mem_cap);

  lcc_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_slot),
    .rdata (rdata)
  );

  lcc_order u_order (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ord_cmd),
    .rd_pos    (rd_pos),
    .rd_slot   (rd_slot),
    .free_slot (free_slot),
    .count     (count)
  );

  lcc_acc u_acc (
    .clk      (clk),
    .op       (acc_op),
    .load_val (used_total),
    .operand  (acc_operand),
    .cap      (mem_cap),
    .used     (used),
    .diff     (diff),
    .over     (over)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            MODE_LOOKUP: state_next = ST_SCAN;
            MODE_STORE:  state_next = refuse_in ? ST_REFUSE : ST_SCAN;
            MODE_CLEAR:  state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match || issue_pos >= count) state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (mode_r == MODE_LOOKUP) begin
          if (out_free) state_next = ST_IDLE;
        end else if (hit_flag) begin
          state_next = ST_ADD;
        end else if (count == CNT_W'(ENTRIES)) begin
          state_next = ST_FULL_RD;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_FULL_RD: state_next = ST_FULL_EV;
      ST_FULL_EV: if (out_free) state_next = ST_INSERT;
      ST_INSERT:  state_next = ST_ADD;
      ST_ADD:     state_next = ST_CHECK;
      ST_CHECK:   state_next = (over && count > CNT_W'(1)) ? ST_EV_RD : ST_DONE;
      ST_EV_RD:   state_next = ST_EV;
      ST_EV:      if (out_free) state_next = ST_CHECK;
      ST_DONE, ST_REFUSE, ST_CLEAR: if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath controls and result fields
  always_comb begin
    emit        = 1'b0;
    e_kind      = KIND_LOOKUP;
    e_hit       = 1'b0;
    e_last      = 1'b0;
    e_key       = '0;
    e_cost      = '0;
    e_pay       = '0;
    e_used      = used_total;
    ord_cmd.op  = ORD_NONE;
    ord_cmd.pos = hit_pos;
    acc_op      = ACC_HOLD;
    acc_operand = cost_r;
    mem_we      = 1'b0;
    mem_waddr   = free_slot;
    mem_wdata   = '{payload: pay_r, cost: cost_r, key: key_r};
    rd_pos      = '0;
    case (state)
      ST_IDLE: begin
        if (accept) acc_op = ACC_LOAD;
      end
      ST_SCAN: rd_pos = issue_pos[IDX_W-1:0];
      ST_RESOLVE: begin
        rd_pos = hit_pos;
        if (mode_r == MODE_LOOKUP) begin
          emit   = out_free;
          e_last = 1'b1;
          if (hit_flag) begin
            e_hit  = 1'b1;
            e_key  = hit_ent.key;
            e_cost = hit_ent.cost;
            e_pay  = hit_ent.payload;
            if (out_free) ord_cmd.op = ORD_TOUCH;
          end else begin
            e_key = key_r;
          end
        end else if (hit_flag) begin
          // replace in place: drop old cost, refresh, rewrite fields
          acc_op      = ACC_SUB;
          acc_operand = hit_ent.cost;
          ord_cmd.op  = ORD_TOUCH;
          mem_we      = 1'b1;
          mem_waddr   = rd_slot;
        end
      end
      ST_FULL_EV, ST_EV: begin
        acc_operand = rdata.cost;
        emit        = out_free;
        e_kind      = KIND_EVICT;
        e_key       = rdata.key;
        e_cost      = rdata.cost;
        e_pay       = rdata.payload;
        e_used      = diff;
        if (out_free) begin
          acc_op     = ACC_SUB;
          ord_cmd.op = ORD_DROP;
        end
      end
      ST_INSERT: begin
        mem_we     = 1'b1;
        ord_cmd.op = ORD_INSERT;
      end
      ST_ADD: acc_op = ACC_ADD;
      ST_DONE: begin
        emit   = out_free;
        e_kind = KIND_STORED;
        e_last = 1'b1;
        e_key  = key_r;
        e_cost = cost_r;
        e_pay  = pay_r;
        e_used = used[DATA_W-1:0];
      end
      ST_REFUSE: begin
        emit   = out_free;
        e_kind = KIND_REFUSED;
        e_last = 1'b1;
        e_key  = key_r;
      end
      ST_CLEAR: begin
        emit   = out_free;
        e_kind = KIND_CLEARED;
        e_last = 1'b1;
        e_used = '0;
        if (out_free) ord_cmd.op = ORD_CLEAR;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mem_cap    <= '0;
      used_total <= '0;
      cmp_vld    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) mem_cap <= cfg_wr_data;
      if (state == ST_DONE && out_free) used_total <= used[DATA_W-1:0];
      if (state == ST_CLEAR && out_free) used_total <= '0;
      if (accept) begin
        cmp_vld <= 1'b0;
      end else if (state == ST_SCAN) begin
        cmp_vld <= !match && issue_pos < count;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= s_tuser;
      key_r     <= s_tdata[31:0];
      cost_r    <= s_tdata[63:32];
      pay_r     <= s_tdata[95:64];
      issue_pos <= '0;
    end else if (state == ST_SCAN) begin
      if (match) begin
        hit_flag <= 1'b1;
        hit_pos  <= cmp_pos;
        hit_ent  <= rdata;
      end else if (issue_pos < count) begin
        issue_pos <= issue_pos + CNT_W'(1);
        cmp_pos   <= issue_pos[IDX_W-1:0];
      end else begin
        hit_flag <= 1'b0;
      end
    end
    if (emit) begin
      m_tuser <= {e_hit, e_kind};
      m_tdata <= {e_used, e_pay, e_cost, e_key};
      m_tlast <= e_last;
    end
  end

`ifndef SYNTHESIS
  // the table never holds more entries than slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  // an accepted store always leaves the total within the budget
  a_store_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> used_total <= mem_cap)
    else $error("byte total above cap after store");

  // clear empties the table and the byte total
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && out_free) |=> (count == '0 && used_total == '0))
    else $error("clear left entries behind");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for byte_capped_lru_cache_unit: random and directed stream traffic
// checked against a behavioral LRU model kept in a scoreboard class. Uses lcc_pkg.

module testbench;
  import lcc_pkg::*;

  localparam int WATCHDOG = 20000;

  // Behavioral copy of the cache plus the queue of results still owed.
  class cache_scoreboard;
    bit          vld[ENTRIES];
    bit [31:0]   key[ENTRIES];
    bit [31:0]   cst[ENTRIES];
    bit [31:0]   pay[ENTRIES];
    int          rnk[ENTRIES];
    bit [31:0]   used;
    bit [31:0]   cap;
    bit [132:0]  owed[$];   // {last, hit, kind, tdata}
    int          errors;

    function void reset_state();
      foreach (vld[i]) vld[i] = 0;
      used = 0; cap = 0; owed.delete(); errors = 0;
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (vld[i]) if (vld[i]) n++;
      return n;
    endfunction

    function int find_slot(bit [31:0] k);
      foreach (vld[i]) if (vld[i] && key[i] == k) return i;
      return -1;
    endfunction

    function int oldest();
      foreach (vld[i]) if (vld[i] && rnk[i] == 0) return i;
      return -1;
    endfunction

    function void unlink(int s);
      foreach (vld[i]) if (vld[i] && i != s && rnk[i] > rnk[s]) rnk[i]--;
    endfunction

    function void promote(int s);
      int n;
      n = live_count();
      unlink(s);
      rnk[s] = n - 1;
    endfunction

    function void owe(kind_t kd, bit h, bit [31:0] k, bit [31:0] c, bit [31:0] p,
                      bit [31:0] u);
      owed.push_back({1'b0, h, kd, u, p, c, k});
    endfunction

    // Predict every result of one accepted input transfer.
    function void note_input(bit [1:0] mode, bit [31:0] k, bit [31:0] c, bit [31:0] p);
      int s, o, n, first;
      bit [32:0] u;
      first = owed.size();
      if (mode == MODE_LOOKUP) begin
        s = find_slot(k);
        if (s >= 0) begin
          promote(s);
          owe(KIND_LOOKUP, 1, key[s], cst[s], pay[s], used);
        end else owe(KIND_LOOKUP, 0, k, 0, 0, used);
      end else if (mode == MODE_STORE) begin
        if (cap == 0 || c > cap) owe(KIND_REFUSED, 0, k, 0, 0, used);
        else begin
          u = used;
          s = find_slot(k);
          if (s >= 0) begin
            u = (u >= cst[s]) ? u - cst[s] : 0;
            promote(s);
          end else begin
            n = live_count();
            if (n >= ENTRIES) begin
              o = oldest();
              u = (u >= cst[o]) ? u - cst[o] : 0;
              unlink(o); vld[o] = 0;
              owe(KIND_EVICT, 0, key[o], cst[o], pay[o], u[31:0]);
              n--;
            end
            foreach (vld[i]) if (!vld[i] && s < 0) s = i;
            vld[s] = 1; rnk[s] = n; key[s] = k;
          end
          cst[s] = c; pay[s] = p;
          u += c;
          while (u > cap) begin
            o = oldest();
            if (o < 0 || o == s) break;
            u = (u >= cst[o]) ? u - cst[o] : 0;
            unlink(o); vld[o] = 0;
            owe(KIND_EVICT, 0, key[o], cst[o], pay[o], u[31:0]);
          end
          used = u[31:0];
          owe(KIND_STORED, 0, k, c, p, used);
        end
      end else if (mode == MODE_CLEAR) begin
        foreach (vld[i]) vld[i] = 0;
        used = 0;
        owe(KIND_CLEARED, 0, 0, 0, 0, 0);
      end
      if (owed.size() > first) owed[owed.size()-1][132] = 1'b1;
    endfunction

    function void check_result(bit [127:0] d, bit [3:0] u, bit l);
      bit [132:0] e, a;
      a = {l, u, d};
      if (owed.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, a);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (e[127:0] != d) begin
        $display("%0t tdata mismatch: expected %h actual %h", $time, e[127:0], d);
        errors++;
      end
      if (e[131:128] != u) begin
        $display("%0t tuser mismatch: expected %h actual %h", $time, e[131:128], u);
        errors++;
      end
      if (e[132] != l) begin
        $display("%0t tlast mismatch: expected %b actual %b", $time, e[132], l);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [127:0] m_tdata;
  logic [3:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_wr_en = 0;
  logic [31:0]  cfg_wr_data = '0;

  cache_scoreboard sb = new();
  int idle_cycles;
  int burst_left;
  bit [31:0] key_pool[8];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  byte_capped_lru_cache_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Receiver: long ready stretches alternating with random stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 < 20) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Check each result transfer and keep the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One input transfer; random gaps come between bursts. Valid stays high
  // inside a burst, so the next item replaces the accepted one in place.
  task automatic send_item(bit [1:0] mode, bit [31:0] k, bit [31:0] c, bit [31:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {p, c, k};
    do @(posedge clk); while (!s_tready);
    sb.note_input(mode, k, c, p);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cap(bit [31:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.cap = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count, bit [31:0] cost_max);
    bit [1:0] m;
    bit [31:0] k;
    repeat (count) begin
      m = ($urandom_range(0, 9) < 5) ? MODE_STORE : MODE_LOOKUP;
      if ($urandom_range(0, 40) == 0) m = MODE_CLEAR;
      if ($urandom_range(0, 50) == 0) m = 2'd3;   // unused mode, ignored
      k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
      send_item(m, k, (cost_max == 0) ? $urandom : $urandom_range(0, cost_max), $urandom);
    end
  endtask

  initial begin
    idle_cycles = 0;
    burst_left = 0;
    sb.reset_state();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Cap zero refuses; lookup miss and clear on an empty table.
    send_item(MODE_STORE, 32'h1, 32'h0, 32'h5);
    send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_CLEAR, 32'h0, 32'h0, 32'h0);
    write_cap(32'd100);
    send_item(MODE_STORE, 32'hA, 32'd101, 32'h1);     // cost above cap
    send_item(MODE_STORE, 32'hA, 32'd100, 32'h2);     // exactly fills cap
    send_item(MODE_STORE, 32'hB, 32'd60, 32'h3);      // evicts A for budget
    send_item(MODE_STORE, 32'hB, 32'd10, 32'h4);      // replace same key
    send_item(MODE_LOOKUP, 32'hB, 32'h0, 32'h0);      // hit
    send_item(MODE_STORE, 32'hC, 32'd0, 32'h5);       // zero cost
    send_item(2'd3, 32'hDEAD, 32'h1, 32'h1);          // ignored
    write_cap(32'hFFFF_FFFF);
    // Fill beyond 16 entries so the full table drops its oldest first.
    for (int i = 0; i < 18; i++) send_item(MODE_STORE, 32'h100 + i, 32'd1, i);
    send_item(MODE_LOOKUP, 32'h102, 32'h0, 32'h0);
    send_item(MODE_CLEAR, 32'h0, 32'h0, 32'h0);

    random_phase(60, 40);
    write_cap(32'd1000);
    random_phase(50, 300);
    write_cap(32'd1);                                 // lowered cap at next store
    random_phase(30, 1);
    write_cap(32'hFFFF_FFFF);
    random_phase(60, 0);
    write_cap(32'd0);
    random_phase(10, 0);
    drain();

    if (sb.errors == 0 && sb.owed.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== byte_capped_lru_cache_unit.f =====
hw/rtl/lcc_pkg.sv
hw/rtl/lcc_ram.sv
hw/rtl/lcc_order.sv
hw/rtl/lcc_acc.sv
hw/rtl/byte_capped_lru_cache_unit.sv
sim/testbench.sv
